// ===== rtl/core/dwa_pkg.sv =====
// Package for the table-driven word acceptor.
// Holds the command and verdict codes and the fixed field widths.
// No dependencies.
package dwa_pkg;

	localparam int STATE_W  = 6;
	localparam int SYMIDX_W = 4;
	localparam int CHAR_W   = 8;
	localparam int TGT_W    = 7;
	localparam int COUNT_W  = 5;

	typedef enum logic [2:0] {
		CMD_ALPHA  = 3'd0,
		CMD_TRANS  = 3'd1,
		CMD_MARK   = 3'd2,
		CMD_SYMBOL = 3'd3,
		CMD_END    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		WHY_NONE      = 2'd0,
		WHY_UNKNOWN   = 2'd1,
		WHY_UNDEFINED = 2'd2,
		WHY_NOT_FINAL = 2'd3
	} why_t;

endpackage

// ===== rtl/core/dwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth are parameters.
module dwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/dwa_alphabet.sv =====
// Alphabet store and parallel character match with first-slot priority.
// Depends on dwa_pkg for the character and count widths.
module dwa_alphabet #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(MAX_SYMBOLS)-1:0]     waddr,
	input  logic [dwa_pkg::CHAR_W-1:0]         wdata,
	input  logic [dwa_pkg::CHAR_W-1:0]         ch,
	input  logic [dwa_pkg::COUNT_W-1:0]        count,
	output logic                               found,
	output logic [$clog2(MAX_SYMBOLS)-1:0]     slot
);

	localparam int SLOT_W = $clog2(MAX_SYMBOLS);

	logic [dwa_pkg::CHAR_W-1:0] alpha_q [MAX_SYMBOLS];
	logic [MAX_SYMBOLS-1:0]     hit;

	always_ff @(posedge clk) begin
		if (we) begin
			alpha_q[waddr] <= wdata;
		end
	end

	// Only the first count slots take part; a count beyond the store covers it all.
	always_comb begin
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			hit[i] = (32'(count) > i) && (alpha_q[i] == ch);
		end
	end

	// Lowest matching slot wins.
	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				slot  = SLOT_W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/dfa_word_acceptor.sv =====
// Top level of the table-driven word acceptor (deterministic automaton).
// Depends on dwa_pkg, dwa_alphabet and dwa_ram.
//
// Usage: the input channel carries one item per transfer. Commands 0 to 2
// load the alphabet, the transition table and the accepting marks; command
// 3 feeds one character of a word, and command 4 closes a word without a
// character (the empty word when nothing came before it). The output
// channel carries one verdict per word: on a character with is_last set,
// or on command 4. Load items and inner characters give no transfer.
// The one configuration register, symbol_count, is written through cfg_wen
// and cfg_wdata; the user must do so only while the block is idle.
// The block itself does not enforce that. An item passes the input register,
// then stage 2, where the transition table read is in flight, then the
// verdict register; a stall on the output side can hold it in any of them.
// Throughput is one item per cycle while the receiver does not stall; the
// path that sets it is the loop from the registered table read data through
// the bounds check and state forwarding back to the table read address.
// Reset clears the accepting marks, the word state and the pipeline, and
// sets symbol_count to 1. The alphabet and table hold garbage until loaded.
// When the receiver stalls, the verdict waits in its register and the
// pipeline behind it holds; in_ready drops once both stages are full.
module dfa_word_acceptor #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [dwa_pkg::COUNT_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          command,
	input  logic [dwa_pkg::STATE_W-1:0]         state_index,
	input  logic [dwa_pkg::SYMIDX_W-1:0]        symbol_index,
	input  logic [dwa_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [dwa_pkg::TGT_W-1:0]    target_state,
	input  logic                                accept_flag,
	input  logic                                is_last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic [1:0]                          verdict_code,
	output logic [dwa_pkg::STATE_W-1:0]         end_state
);

	// Targets are at most 63, so no more than 64 states are ever reachable.
	localparam int EFF_STATES = (MAX_STATES > 64) ? 64 : MAX_STATES;
	localparam int ST_AW      = $clog2(EFF_STATES);
	localparam int SLOT_W     = $clog2(MAX_SYMBOLS);
	localparam int TAB_DEPTH  = EFF_STATES * (2 ** SLOT_W);

	localparam int SW = dwa_pkg::STATE_W;

	// Configuration register.
	logic [dwa_pkg::COUNT_W-1:0] symbol_count_q;

	// Stage 1: input register.
	logic                          valid_s1;
	dwa_pkg::cmd_t                 cmd_s1;
	logic [SW-1:0]                 state_index_s1;
	logic [dwa_pkg::SYMIDX_W-1:0]  symbol_index_s1;
	logic [dwa_pkg::CHAR_W-1:0]    char_s1;
	logic [dwa_pkg::TGT_W-1:0]     target_s1;
	logic                          flag_s1;
	logic                          last_s1;

	// Stage 2: table read in flight, word state before this item.
	logic                          valid_s2;
	dwa_pkg::cmd_t                 cmd_s2;
	logic                          last_s2;
	logic                          found_s2;
	logic [SW-1:0]                 cur_s2;
	dwa_pkg::why_t                 why_s2;

	// Architectural word state once stage 2 is empty.
	logic [SW-1:0]                 state_q;
	dwa_pkg::why_t                 why_q;
	logic [EFF_STATES-1:0]         marks_q;

	// Verdict register.
	logic                          out_valid_q;
	logic                          accepted_q;
	dwa_pkg::why_t                 verdict_q;
	logic [SW-1:0]                 end_state_q;

	logic                          s2_go;
	logic                          adv;
	logic                          match_found;
	logic [SLOT_W-1:0]             match_slot;
	logic [SW-1:0]                 eff_state;
	dwa_pkg::why_t                 eff_why;
	logic                          tab_we;
	logic                          tab_re;
	logic [ST_AW+SLOT_W-1:0]       tab_waddr;
	logic [ST_AW+SLOT_W-1:0]       tab_raddr;
	logic [dwa_pkg::TGT_W-1:0]     tab_rdata;
	logic                          alpha_we;
	logic                          mark_we;

	logic [SW-1:0]                 step_state;
	dwa_pkg::why_t                 step_why;
	logic                          is_verdict;
	dwa_pkg::why_t                 verdict_why;
	logic [SW-1:0]                 next_state;
	dwa_pkg::why_t                 next_why;

	// Handshake: stage 2 leaves when the verdict register can take a word,
	// stage 1 moves on when stage 2 is free or leaving.
	assign s2_go    = !out_valid_q || out_ready;
	assign adv      = !valid_s2 || s2_go;
	assign in_ready = !valid_s1 || adv;

	// Loads and table reads are issued as the item leaves stage 1, so every
	// access happens in item order.
	assign alpha_we = valid_s1 && adv && (cmd_s1 == dwa_pkg::CMD_ALPHA)
		&& (32'(symbol_index_s1) < MAX_SYMBOLS);
	assign tab_we   = valid_s1 && adv && (cmd_s1 == dwa_pkg::CMD_TRANS)
		&& (32'(state_index_s1) < EFF_STATES) && (32'(symbol_index_s1) < MAX_SYMBOLS);
	assign mark_we  = valid_s1 && adv && (cmd_s1 == dwa_pkg::CMD_MARK)
		&& (32'(state_index_s1) < EFF_STATES);
	assign tab_re   = valid_s1 && adv && (cmd_s1 == dwa_pkg::CMD_SYMBOL);

	assign tab_waddr = {ST_AW'(state_index_s1), SLOT_W'(symbol_index_s1)};

	// The word state seen by the item in stage 1 is the one left by stage 2.
	assign eff_state = valid_s2 ? next_state : state_q;
	assign eff_why   = valid_s2 ? next_why   : why_q;
	assign tab_raddr = {eff_state[ST_AW-1:0], match_slot};

	dwa_alphabet #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_alphabet (
		.clk   (clk),
		.we    (alpha_we),
		.waddr (SLOT_W'(symbol_index_s1)),
		.wdata (char_s1),
		.ch    (char_s1),
		.count (symbol_count_q),
		.found (match_found),
		.slot  (match_slot)
	);

	dwa_ram #(
		.WIDTH(dwa_pkg::TGT_W),
		.DEPTH(TAB_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (target_s1),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	// One step of the automaton for the item in stage 2. A rejected word
	// keeps its reason and state until its verdict.
	always_comb begin
		step_state = cur_s2;
		step_why   = why_s2;
		if ((cmd_s2 == dwa_pkg::CMD_SYMBOL) && (why_s2 == dwa_pkg::WHY_NONE)) begin
			if (!found_s2) begin
				step_why = dwa_pkg::WHY_UNKNOWN;
			end else if (tab_rdata[dwa_pkg::TGT_W-1]
				|| (32'(tab_rdata[SW-1:0]) >= EFF_STATES)) begin
				step_why = dwa_pkg::WHY_UNDEFINED;
			end else begin
				step_state = tab_rdata[SW-1:0];
			end
		end
	end

	always_comb begin
		is_verdict = (cmd_s2 == dwa_pkg::CMD_END)
			|| ((cmd_s2 == dwa_pkg::CMD_SYMBOL) && last_s2);
		verdict_why = step_why;
		if ((step_why == dwa_pkg::WHY_NONE) && !marks_q[step_state[ST_AW-1:0]]) begin
			verdict_why = dwa_pkg::WHY_NOT_FINAL;
		end
		// A verdict sends the next word back to the start state.
		next_state = is_verdict ? '0 : step_state;
		next_why   = is_verdict ? dwa_pkg::WHY_NONE : step_why;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= dwa_pkg::COUNT_W'(1);
		end else if (cfg_wen) begin
			symbol_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1          <= dwa_pkg::cmd_t'(command);
			state_index_s1  <= state_index;
			symbol_index_s1 <= symbol_index;
			char_s1         <= char_code;
			target_s1       <= target_state;
			flag_s1         <= accept_flag;
			last_s1         <= is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			cmd_s2   <= cmd_s1;
			last_s2  <= last_s1;
			found_s2 <= match_found;
			cur_s2   <= eff_state;
			why_s2   <= eff_why;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			why_q   <= dwa_pkg::WHY_NONE;
			marks_q <= '0;
		end else begin
			if (valid_s2 && s2_go) begin
				state_q <= next_state;
				why_q   <= next_why;
			end
			if (mark_we) begin
				marks_q[ST_AW'(state_index_s1)] <= flag_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= valid_s2 && is_verdict;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && valid_s2 && is_verdict) begin
			accepted_q  <= (verdict_why == dwa_pkg::WHY_NONE);
			verdict_q   <= verdict_why;
			end_state_q <= step_state;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign verdict_code = verdict_q;
	assign end_state    = end_state_q;

endmodule

// ===== dv/dwa_verdict_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker for dfa_word_acceptor: watches the config port and both channels,
// keeps its own copy of the automaton and compares every verdict transfer.
// Depends on dwa_pkg for field widths and the command and verdict codes.
module dwa_verdict_checker
	import dwa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         command,
	input  logic [STATE_W-1:0] state_index,
	input  logic [SYMIDX_W-1:0] symbol_index,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [TGT_W-1:0]   target_state,
	input  logic               accept_flag,
	input  logic               is_last,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               accepted,
	input  logic [1:0]         verdict_code,
	input  logic [STATE_W-1:0] end_state,
	output int                 fail_count,
	output int                 pending
);

	localparam int STATE_COUNT = 1 << STATE_W;
	localparam int SLOT_COUNT  = 1 << SYMIDX_W;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic               is_accepted;
		why_t               code;
		logic [STATE_W-1:0] state;
	} verdict_t;

	logic [TGT_W-1:0]       edge_tbl [STATE_COUNT*SLOT_COUNT];
	logic [CHAR_W-1:0]      alpha_slots [SLOT_COUNT];
	logic [STATE_COUNT-1:0] final_marks;
	logic [STATE_W-1:0]     walk_state;
	why_t                   walk_why;
	logic [COUNT_W-1:0]     slot_limit;
	verdict_t               verdicts_due [$];
	verdict_t               want_v;
	int                     mismatches;

	// One character of a word. Once a word is rejected it stays rejected.
	function automatic void take_char(logic [CHAR_W-1:0] ch);
		int n;
		int hit;
		logic [TGT_W-1:0] tgt;
		if (walk_why != WHY_NONE)
			return;
		n = (slot_limit > SLOT_COUNT) ? SLOT_COUNT : int'(slot_limit);
		hit = -1;
		for (int s = 0; s < n; s++) begin
			if (hit < 0 && alpha_slots[s] == ch)
				hit = s;
		end
		if (hit < 0) begin
			walk_why = WHY_UNKNOWN;
			return;
		end
		tgt = edge_tbl[{walk_state, hit[SYMIDX_W-1:0]}];
		// Targets are signed; with 64 states every negative one is undefined.
		if (tgt[TGT_W-1]) begin
			walk_why = WHY_UNDEFINED;
			return;
		end
		walk_state = tgt[STATE_W-1:0];
	endfunction

	function automatic verdict_t close_word();
		verdict_t v;
		v.code = walk_why;
		if (walk_why == WHY_NONE && !final_marks[walk_state])
			v.code = WHY_NOT_FINAL;
		v.is_accepted = (v.code == WHY_NONE);
		v.state = walk_state;
		walk_state = '0;
		walk_why = WHY_NONE;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_marks = '0;
			walk_state = '0;
			walk_why = WHY_NONE;
			slot_limit = COUNT_W'(1);
			verdicts_due.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// A verdict leaving now cannot belong to an item entering now.
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected verdict acc=%0b code=%0d state=%0d",
							$time, accepted, verdict_code, end_state);
				end else begin
					want_v = verdicts_due.pop_front();
					if (accepted !== want_v.is_accepted || verdict_code !== want_v.code
							|| end_state !== want_v.state) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: expected acc=%0b code=%0d state=%0d, %s%0b %0d %0d",
								$time, want_v.is_accepted, want_v.code, want_v.state,
								"got acc/code/state ", accepted, verdict_code, end_state);
					end
				end
			end
			if (cfg_wen === 1'b1)
				slot_limit = cfg_wdata;
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				case (command)
					CMD_ALPHA: alpha_slots[symbol_index] = char_code;
					CMD_TRANS: edge_tbl[{state_index, symbol_index}] = target_state;
					CMD_MARK: final_marks[state_index] = accept_flag;
					CMD_SYMBOL: begin
						take_char(char_code);
						if (is_last)
							verdicts_due.push_back(close_word());
					end
					CMD_END: verdicts_due.push_back(close_word());
					default: ;
				endcase
			end
			fail_count <= mismatches;
			pending <= verdicts_due.size();
		end
	end

endmodule

// ===== dv/tb_dfa_word_acceptor.sv =====
`timescale 1ns / 100ps
// Testbench top for dfa_word_acceptor: drives load items and words, stalls the verdict side,
// and reports the verdict of dwa_verdict_checker. Depends on dwa_pkg and dwa_verdict_checker.
module tb_dfa_word_acceptor;
	import dwa_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 5;
	localparam int SLOT_COUNT    = 1 << SYMIDX_W;
	// Words only ever reach states 0 to LIVE_STATES-1 and the top state, so only
	// the table rows of those states need loading.
	localparam int LIVE_STATES   = 8;
	localparam logic [STATE_W-1:0] TOP_STATE = '1;
	// The pipeline is three stages deep; this wait lets it go quiet.
	localparam int SETTLE_CYCLES = 6;
	// Cycles without any transfer before the run is declared hung.
	localparam int QUIET_LIMIT   = 4000;
	// Command codes the block has no use for; it must swallow them silently.
	localparam logic [2:0] SPARE_CMD_LO = 3'd5;
	localparam logic [2:0] SPARE_CMD_HI = 3'd7;

	// One input item, field for field as the ports carry it.
	typedef struct packed {
		logic [2:0]          cmd;
		logic [STATE_W-1:0]  st;
		logic [SYMIDX_W-1:0] slot;
		logic [CHAR_W-1:0]   ch;
		logic [TGT_W-1:0]    tgt;
		logic                flag;
		logic                last;
	} item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [COUNT_W-1:0]  cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [2:0]          command = '0;
	logic [STATE_W-1:0]  state_index = '0;
	logic [SYMIDX_W-1:0] symbol_index = '0;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [TGT_W-1:0]    target_state = '0;
	logic                accept_flag = 1'b0;
	logic                is_last = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                accepted;
	logic [1:0]          verdict_code;
	logic [STATE_W-1:0]  end_state;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int tx_idle_pct = 17;
	int rx_idle_pct = 62;
	int items_sent = 0;
	// Slots the block currently searches, and what the stimulus last wrote to each.
	// Word characters are drawn from here so that most of them are known symbols.
	int live_slots = 1;
	logic [CHAR_W-1:0] alpha_copy [SLOT_COUNT];

	dfa_word_acceptor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.state_index  (state_index),
		.symbol_index (symbol_index),
		.char_code    (char_code),
		.target_state (target_state),
		.accept_flag  (accept_flag),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.verdict_code (verdict_code),
		.end_state    (end_state)
	);

	dwa_verdict_checker verdict_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.state_index  (state_index),
		.symbol_index (symbol_index),
		.char_code    (char_code),
		.target_state (target_state),
		.accept_flag  (accept_flag),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.verdict_code (verdict_code),
		.end_state    (end_state),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The verdict side stalls at random; the rate changes from phase to phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Any transfer on either channel counts as progress. A long quiet stretch means
	// the block has hung, so the run ends there with a failure.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("** dfa_word_acceptor: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Every field random, so that the fields a command ignores still toggle.
	function automatic item_t fresh(logic [2:0] cmd);
		item_t it;
		it.cmd = cmd;
		it.st = STATE_W'($urandom);
		it.slot = SYMIDX_W'($urandom);
		it.ch = CHAR_W'($urandom);
		it.tgt = TGT_W'($urandom);
		it.flag = 1'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	// Mostly defined targets among the loaded rows, so words run deep; now and then
	// the top state, and now and then a negative target.
	function automatic logic [TGT_W-1:0] edge_target();
		logic [TGT_W-1:0] t;
		t = TGT_W'($urandom_range(LIVE_STATES - 1));
		if ($urandom_range(99) < 4)
			t = TGT_W'(TOP_STATE);
		if ($urandom_range(99) < 12)
			t[TGT_W-1] = 1'b1;
		return t;
	endfunction

	// A character from the searched slots, or now and then any byte at all.
	function automatic logic [CHAR_W-1:0] pick_char();
		if (live_slots == 0 || $urandom_range(99) < 8)
			return CHAR_W'($urandom);
		return alpha_copy[$urandom_range(live_slots - 1)];
	endfunction

	function automatic item_t random_load();
		item_t it;
		case ($urandom_range(2))
			0: begin
				it = fresh(CMD_ALPHA);
				// Copying another slot makes duplicates, where the lower slot must win.
				if ($urandom_range(3) == 0)
					it.ch = alpha_copy[$urandom_range(SLOT_COUNT - 1)];
			end
			1: begin
				it = fresh(CMD_TRANS);
				it.tgt = edge_target();
			end
			default: it = fresh(CMD_MARK);
		endcase
		return it;
	endfunction

	// Presents one item and returns at the edge where it is transferred. Called at a
	// rising edge. Valid drops only for a sender gap, and is raised again at a later
	// edge, so it never sees two assignments in one time step. Ready is looked at on
	// the falling edge, where nothing that the block drives is still changing.
	task automatic send_item(item_t it);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		command <= it.cmd;
		state_index <= it.st;
		symbol_index <= it.slot;
		char_code <= it.ch;
		target_state <= it.tgt;
		accept_flag <= it.flag;
		is_last <= it.last;
		if (it.cmd == CMD_ALPHA)
			alpha_copy[it.slot] = it.ch;
		@(negedge clk);
		while (in_ready !== 1'b1)
			@(negedge clk);
		@(posedge clk);
		if (it.cmd <= CMD_END)
			items_sent++;
	endtask

	task automatic word_char(logic [CHAR_W-1:0] ch, logic last);
		item_t it;
		it = fresh(CMD_SYMBOL);
		it.ch = ch;
		it.last = last;
		send_item(it);
	endtask

	task automatic put_edge(logic [STATE_W-1:0] st, logic [SYMIDX_W-1:0] slot,
			logic [TGT_W-1:0] tgt);
		item_t it;
		it = fresh(CMD_TRANS);
		it.st = st;
		it.slot = slot;
		it.tgt = tgt;
		send_item(it);
	endtask

	// Stops sending, waits for every outstanding verdict and then lets the pipeline
	// empty, since load items and inner characters leave no verdict to wait for.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// symbol_count is only written with the block idle.
	task automatic set_symbol_count(logic [COUNT_W-1:0] v);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		live_slots = (v > SLOT_COUNT) ? SLOT_COUNT : int'(v);
	endtask

	task automatic run_word();
		int len;
		bit by_end;
		item_t it;
		len = $urandom_range(1, 8);
		by_end = ($urandom_range(99) < 12);
		for (int i = 0; i < len; i++) begin
			// Loads in the middle of a word take effect at once.
			if ($urandom_range(99) < 6)
				send_item(random_load());
			it = fresh(CMD_SYMBOL);
			it.ch = pick_char();
			it.last = !by_end && (i == len - 1);
			send_item(it);
		end
		if (by_end)
			send_item(fresh(CMD_END));
	endtask

	// Random phase: mostly whole words with random content, the rest loose loads,
	// empty words and spare commands.
	task automatic run_phase(logic [COUNT_W-1:0] count, int tx_pct, int rx_pct, int n);
		int start;
		set_symbol_count(count);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = items_sent;
		while (items_sent - start < n) begin
			case ($urandom_range(19))
				0, 1, 2: send_item(random_load());
				3: send_item(fresh(CMD_END));
				4: send_item(fresh(3'($urandom_range(SPARE_CMD_HI, SPARE_CMD_LO))));
				default: run_word();
			endcase
		end
	endtask

	initial begin
		item_t it;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With symbol_count at zero every character is unknown, so words can be sent
		// before the alphabet or the table hold anything. No state is accepting yet,
		// so the empty word ends in a non-accepting state.
		set_symbol_count('0);
		send_item(fresh(CMD_END));
		for (int c = int'(SPARE_CMD_LO); c <= int'(SPARE_CMD_HI); c++)
			send_item(fresh(3'(c)));
		// A rejected word ignores what follows up to its last character.
		word_char(8'h00, 1'b0);
		word_char(8'hFF, 1'b1);
		// The end command closes a word that is still open.
		word_char(8'hA5, 1'b0);
		send_item(fresh(CMD_END));

		// Load every alphabet slot and the table rows of every state that a word can
		// reach, so that no word can read an entry that was never written.
		set_symbol_count(COUNT_W'(SLOT_COUNT));
		for (int s = 0; s < SLOT_COUNT; s++) begin
			it = fresh(CMD_ALPHA);
			it.slot = SYMIDX_W'(s);
			send_item(it);
		end
		for (int st = 0; st < LIVE_STATES; st++) begin
			for (int s = 0; s < SLOT_COUNT; s++)
				put_edge(STATE_W'(st), SYMIDX_W'(s), edge_target());
		end
		for (int s = 0; s < SLOT_COUNT; s++)
			put_edge(TOP_STATE, SYMIDX_W'(s), edge_target());

		// Directed cases on the loaded table. First the empty word with the start
		// state marked accepting, then unmarked again.
		it = fresh(CMD_MARK);
		it.st = '0;
		it.flag = 1'b1;
		send_item(it);
		send_item(fresh(CMD_END));
		it.flag = 1'b0;
		send_item(it);
		send_item(fresh(CMD_END));
		// Extreme characters; 8'hFF sits in slot 1 and again in slot 15.
		it = fresh(CMD_ALPHA);
		it.slot = '0;
		it.ch = 8'h00;
		send_item(it);
		it.slot = 4'd1;
		it.ch = 8'hFF;
		send_item(it);
		it.slot = 4'd15;
		send_item(it);
		put_edge('0, '0, 7'd63);
		it = fresh(CMD_MARK);
		it.st = 6'd63;
		it.flag = 1'b1;
		send_item(it);
		word_char(8'h00, 1'b1);
		// Undefined transitions: minus one, then the most negative target.
		put_edge('0, '0, 7'h7F);
		word_char(8'h00, 1'b1);
		put_edge('0, '0, 7'h40);
		word_char(8'h00, 1'b0);
		word_char(8'h00, 1'b1);
		// The first matching slot wins: slot 15 leads nowhere, slot 1 to state 63.
		put_edge('0, 4'd1, 7'd63);
		put_edge('0, 4'd15, 7'h7F);
		word_char(8'hFF, 1'b1);
		// A table write in the middle of a word is seen by its next character.
		word_char(8'hFF, 1'b0);
		put_edge(6'd63, 4'd1, 7'd5);
		word_char(8'hFF, 1'b1);
		word_char(8'hFF, 1'b0);
		send_item(fresh(CMD_END));

		// Random phases across symbol_count settings, counts above the slot count
		// and zero among them. The sender idles lightly while the receiver stalls
		// hard, then the other way round, then neither idles.
		run_phase(COUNT_W'(16), 17, 62, 110);
		run_phase(COUNT_W'(31), 17, 62, 70);
		run_phase(COUNT_W'(1), 62, 17, 70);
		run_phase(COUNT_W'(0), 62, 17, 30);
		run_phase(COUNT_W'(9), 62, 17, 70);
		run_phase(COUNT_W'(16), 0, 0, 110);

		drain();
		if (fail_count == 0)
			$display("** dfa_word_acceptor: PASSED **");
		else
			$display("** dfa_word_acceptor: FAILED **");
		$finish;
	end

endmodule
